// ===== hw/rtl/mcrgb_pkg.sv =====
`default_nettype none

package mcrgb_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  localparam logic [CfgIdxW-1:0] CfgTwoRows   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEmitAlpha = 1'b1;

  localparam logic [8:0] ChromaCenter = 9'd128;

  localparam logic signed [16:0] CoefCrRed   = 17'sd22971;
  localparam logic signed [16:0] CoefCbGreen = 17'sd11277;
  localparam logic signed [16:0] CoefCrGreen = 17'sd23401;
  localparam logic signed [16:0] CoefCbBlue  = 17'sd29033;

  localparam logic signed [25:0] RoundHalf14 = 26'sd8192;
  localparam logic signed [25:0] RoundHalf15 = 26'sd16384;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaNone   = 8'h00;

  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] cr;
    logic [7:0] y_tl;
    logic [7:0] y_tr;
    logic [7:0] y_bl;
    logic [7:0] y_br;
    logic       has_right;
  } chroma_beat_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Pixel slot is {row, column}.
  typedef struct packed {
    rgb_t [3:0] px;
    logic       has_right;
  } quad_t;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcrgb_in_if.sv =====
`default_nettype none

interface mcrgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cb_sample;
  logic [7:0] cr_sample;
  logic [7:0] y_top_left;
  logic [7:0] y_top_right;
  logic [7:0] y_bottom_left;
  logic [7:0] y_bottom_right;
  logic       has_right;

  modport source (
    output valid, cb_sample, cr_sample, y_top_left, y_top_right,
           y_bottom_left, y_bottom_right, has_right,
    input  ready
  );
  modport sink (
    input  valid, cb_sample, cr_sample, y_top_left, y_top_right,
           y_bottom_left, y_bottom_right, has_right,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mcrgb_out_if.sv =====
`default_nettype none

interface mcrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       row_index;
  logic       column_in_pair;
  logic       last;

  modport source (
    output valid, red, green, blue, alpha, row_index, column_in_pair, last,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, alpha, row_index, column_in_pair, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mcrgb_pipe.sv =====
`default_nettype none

module mcrgb_pipe
  import mcrgb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire chroma_beat_t in_beat_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output quad_t             out_quad_o,
  input  wire logic         out_ready_i
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  logic signed [8:0]  cb1_q, cr1_q;
  logic [3:0][7:0]    y1_q, y2_q, y3_q;
  logic               rt1_q, rt2_q, rt3_q;

  logic signed [25:0] pr2_q, pgb2_q, pgr2_q, pb2_q;

  logic signed [25:0] rsum, gsum, bsum;
  logic signed [8:0]  radd3_q, gsub3_q, badd3_q;

  quad_t              quad_d, quad4_q;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cb1_q <= $signed({1'b0, in_beat_i.cb} - ChromaCenter);
      cr1_q <= $signed({1'b0, in_beat_i.cr} - ChromaCenter);
      y1_q  <= {in_beat_i.y_br, in_beat_i.y_bl, in_beat_i.y_tr, in_beat_i.y_tl};
      rt1_q <= in_beat_i.has_right;
    end
    if (en2) begin
      pr2_q  <= cr1_q * CoefCrRed;
      pgb2_q <= cb1_q * CoefCbGreen;
      pgr2_q <= cr1_q * CoefCrGreen;
      pb2_q  <= cb1_q * CoefCbBlue;
      y2_q   <= y1_q;
      rt2_q  <= rt1_q;
    end
    if (en3) begin
      radd3_q <= rsum[22:14];
      gsub3_q <= gsum[23:15];
      badd3_q <= bsum[22:14];
      y3_q    <= y2_q;
      rt3_q   <= rt2_q;
    end
    if (en4) begin
      quad4_q <= quad_d;
    end
  end

  assign rsum = pr2_q + RoundHalf14;
  assign gsum = pgb2_q + pgr2_q + RoundHalf15;
  assign bsum = pb2_q + RoundHalf14;

  always_comb begin
    logic signed [10:0] yv;
    quad_d.has_right = rt3_q;
    for (int i = 0; i < 4; i++) begin
      yv = $signed({3'b000, y3_q[i]});
      quad_d.px[i].r = clamp_byte(yv + {{2{radd3_q[8]}}, radd3_q});
      quad_d.px[i].g = clamp_byte(yv - {{2{gsub3_q[8]}}, gsub3_q});
      quad_d.px[i].b = clamp_byte(yv + {{2{badd3_q[8]}}, badd3_q});
    end
  end

  assign out_valid_o = v4_q;
  assign out_quad_o  = quad4_q;

endmodule

`default_nettype wire

// ===== hw/rtl/merged_chroma_upsample_ycbcr_to_rgb.sv =====
// An accepted chroma beat passes the four pipeline stages and the serializer register
// before its first pixel beat. The output serializer emits one pixel beat per cycle
// while the sink is ready; a chroma beat yields one, two or four pixel beats by mode
// and odd-width end. The conversion pipeline accepts a new beat every cycle while it
// has room. Reset clears all valid bits and both configuration registers.
`default_nettype none

module merged_chroma_upsample_ycbcr_to_rgb
  import mcrgb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  mcrgb_in_if.sink                 in_ch,
  mcrgb_out_if.source              out_ch
);

  logic         two_rows_q, emit_alpha_q;
  chroma_beat_t in_beat;
  logic         pipe_valid, load;
  quad_t        pipe_quad;

  quad_t        quad_q, quad_d;
  logic         sv_q, sv_d;
  logic [1:0]   k_q, k_d;
  logic         last, beat_done;
  rgb_t         px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_rows_q   <= 1'b0;
      emit_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTwoRows)   two_rows_q   <= cfg_data_i[0];
      if (cfg_idx_i == CfgEmitAlpha) emit_alpha_q <= cfg_data_i[0];
    end
  end

  assign in_beat.cb        = in_ch.cb_sample;
  assign in_beat.cr        = in_ch.cr_sample;
  assign in_beat.y_tl      = in_ch.y_top_left;
  assign in_beat.y_tr      = in_ch.y_top_right;
  assign in_beat.y_bl      = in_ch.y_bottom_left;
  assign in_beat.y_br      = in_ch.y_bottom_right;
  assign in_beat.has_right = in_ch.has_right;

  mcrgb_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_beat_i   (in_beat),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (pipe_valid),
    .out_quad_o  (pipe_quad),
    .out_ready_i (load)
  );

  assign last      = (k_q[1] == two_rows_q) && (k_q[0] || !quad_q.has_right);
  assign beat_done = sv_q && out_ch.ready;
  assign load      = !sv_q || (beat_done && last);

  always_comb begin
    sv_d   = sv_q;
    k_d    = k_q;
    quad_d = quad_q;
    if (load) begin
      sv_d   = pipe_valid;
      k_d    = 2'd0;
      quad_d = pipe_quad;
    end else if (beat_done) begin
      k_d = k_q + (quad_q.has_right ? 2'd1 : 2'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      k_q  <= 2'd0;
    end else begin
      sv_q <= sv_d;
      k_q  <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
  end

  assign px = quad_q.px[k_q];

  assign out_ch.valid          = sv_q;
  assign out_ch.red            = px.r;
  assign out_ch.green          = px.g;
  assign out_ch.blue           = px.b;
  assign out_ch.alpha          = emit_alpha_q ? AlphaOpaque : AlphaNone;
  assign out_ch.row_index      = k_q[1];
  assign out_ch.column_in_pair = k_q[0];
  assign out_ch.last           = last;

endmodule

`default_nettype wire
